// ===== sv/piecewise_cubic_bezier_eval_macros.svh =====
// Assertion macros shared by the piecewise cubic Bezier evaluator modules.
// Expects clk and the active-low synchronous reset rst_n in the using scope.
`ifndef PIECEWISE_CUBIC_BEZIER_EVAL_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_EVAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcbe_pkg.sv =====
// Shared types and constants for the piecewise cubic Bezier evaluator.
// No dependencies; imported by every module of the block.
package pcbe_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = 7;
  localparam int NUM_ROLES    = 4;
  localparam int COORD_W      = 32;
  localparam int PT_W         = 2 * COORD_W;
  localparam int FBITS        = 16;
  localparam int FRAC_W       = FBITS + 1;
  localparam int PROD_W       = FBITS + CNT_W;

  // Input tdata layout, lowest bit first.
  localparam int SEG_LSB    = 0;
  localparam int ROLE_LSB   = SEG_LSB + 6;
  localparam int X_LSB      = ROLE_LSB + 2;
  localparam int Y_LSB      = X_LSB + COORD_W;
  localparam int T_LSB      = Y_LSB + COORD_W;
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = PT_W;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [1:0] {
    ROLE_START,
    ROLE_CTRL1,
    ROLE_CTRL2,
    ROLE_END
  } role_t;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1) << FBITS;

  // Item queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Bernstein weight arithmetic.
  localparam int SQ_W   = 2 * FBITS + 1;
  localparam int RAW_W  = 3 * FBITS + 1;
  localparam int BSUM_W = RAW_W + 2;
  localparam int WGT_SH = 18;
  localparam int WGT_W  = 2 * FBITS - WGT_SH + FBITS - 1 + 2;
  localparam logic [BSUM_W-1:0] WGT_ROUND = BSUM_W'(1) << (WGT_SH - 1);

  // Accumulation and final rounding.
  localparam int ACC_W  = 64;
  localparam int ACC_SH = 30;
  localparam int RES_W  = ACC_W - ACC_SH;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (ACC_SH - 1);
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Classified item: addr is the load segment or the evaluated segment.
  typedef struct packed {
    logic                        eval;
    logic [SEG_W-1:0]            addr;
    role_t                       role;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic [FRAC_W-1:0]           frac;
  } pcbe_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pcbe_qstat_t;

endpackage

// ===== sv/pcbe_front.sv =====
// Front end: accepts input items, holds segment_count, maps t to segment and fraction.
// Depends on pcbe_pkg; feeds pcbe_queue.
module pcbe_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pcbe_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [pcbe_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcbe_pkg::CNT_W-1:0]      cfg_data,
  input  pcbe_pkg::pcbe_qstat_t           q_stat,
  output logic                            push,
  output pcbe_pkg::pcbe_item_t            push_item
);
  import pcbe_pkg::*;

  logic [CNT_W-1:0]  seg_count_r, seg_count_nxt;
  logic              fr_v_r, fr_v_nxt;
  pcbe_item_t        fr_item_r, fr_item_nxt;
  logic              in_fire;
  logic [FRAC_W-1:0] t_raw, t_sat;
  logic [PROD_W-1:0] prod;

  assign cfg_ready = 1'b1;
  assign push      = fr_v_r && !q_stat.full;
  assign in_tready = !fr_v_r || !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;
  assign push_item = fr_item_r;

  // Clamp the segment count once, at write time.
  always_comb begin
    seg_count_nxt = seg_count_r;
    if (cfg_valid) begin
      if (cfg_data == '0) begin
        seg_count_nxt = CNT_W'(1);
      end else if (cfg_data > CNT_W'(MAX_SEGMENTS)) begin
        seg_count_nxt = CNT_W'(MAX_SEGMENTS);
      end else begin
        seg_count_nxt = cfg_data;
      end
    end
  end

  // Classify: map t onto segment index and local fraction.
  always_comb begin
    t_raw = in_tdata[T_LSB +: FRAC_W];
    t_sat = (t_raw > ONE_Q16) ? ONE_Q16 : t_raw;
    prod  = PROD_W'(t_sat[FBITS-1:0]) * PROD_W'(seg_count_r);

    fr_item_nxt.eval = (in_tuser[0] == FUNC_EVAL);
    fr_item_nxt.role = role_t'(in_tdata[ROLE_LSB +: 2]);
    fr_item_nxt.x    = in_tdata[X_LSB +: COORD_W];
    fr_item_nxt.y    = in_tdata[Y_LSB +: COORD_W];
    if (!fr_item_nxt.eval) begin
      fr_item_nxt.addr = in_tdata[SEG_LSB +: SEG_W];
      fr_item_nxt.frac = '0;
    end else if (t_sat == ONE_Q16) begin
      fr_item_nxt.addr = SEG_W'(seg_count_r - 1'b1);
      fr_item_nxt.frac = ONE_Q16;
    end else begin
      fr_item_nxt.addr = prod[FBITS +: SEG_W];
      fr_item_nxt.frac = {1'b0, prod[FBITS-1:0]};
    end

    fr_v_nxt = in_fire || (fr_v_r && !push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= CNT_W'(1);
      fr_v_r      <= 1'b0;
    end else begin
      seg_count_r <= seg_count_nxt;
      fr_v_r      <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

// ===== sv/pcbe_queue.sv =====
// Short item queue between the front end and the evaluation back end.
// Depends on pcbe_pkg and the assertion macros header.
`include "piecewise_cubic_bezier_eval_macros.svh"

module pcbe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pcbe_pkg::pcbe_item_t  push_item,
  input  logic                  pop,
  output pcbe_pkg::pcbe_item_t  head,
  output pcbe_pkg::pcbe_qstat_t q_stat
);
  import pcbe_pkg::*;

  pcbe_item_t        q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = q_mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PCBE_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
  `PCBE_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
  `PCBE_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule

// ===== sv/pcbe_back.sv =====
// Back end: control point banks and the Bernstein evaluation pipeline with output register.
// Depends on pcbe_pkg and the assertion macros header; drains pcbe_queue.
`include "piecewise_cubic_bezier_eval_macros.svh"

module pcbe_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pcbe_pkg::pcbe_item_t             head,
  input  pcbe_pkg::pcbe_qstat_t            q_stat,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcbe_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pcbe_pkg::*;

  // One bank per point role, so all four points of a segment read together.
  logic [PT_W-1:0] bank_mem [NUM_ROLES][MAX_SEGMENTS];

  logic en;

  // Stage 1: bank read data, fraction and its complement.
  logic              v1_r;
  logic [PT_W-1:0]   rd_r  [NUM_ROLES];
  logic [FRAC_W-1:0] f1_r, s1_r;
  // Stage 2: squares.
  logic              v2_r;
  logic [FRAC_W-1:0] f2_r, s2_r;
  logic [SQ_W-1:0]   sqs2_r, sqf2_r;
  logic [PT_W-1:0]   pt2_r [NUM_ROLES];
  // Stage 3: cubic terms.
  logic              v3_r;
  logic [RAW_W-1:0]  raw3_r [NUM_ROLES];
  logic [RAW_W-1:0]  raw3_nxt [NUM_ROLES];
  logic [PT_W-1:0]   pt3_r [NUM_ROLES];
  // Stage 4: rounded weights.
  logic              v4_r;
  logic [WGT_W-1:0]  w4_r [NUM_ROLES];
  logic [WGT_W-1:0]  w4_nxt [NUM_ROLES];
  logic [PT_W-1:0]   pt4_r [NUM_ROLES];
  // Stage 5: weighted coordinates.
  logic                    v5_r;
  logic signed [ACC_W-1:0] px5_r [NUM_ROLES];
  logic signed [ACC_W-1:0] py5_r [NUM_ROLES];
  logic signed [ACC_W-1:0] px5_nxt [NUM_ROLES];
  logic signed [ACC_W-1:0] py5_nxt [NUM_ROLES];
  // Stage 6: pair sums, rounding bias folded in.
  logic                    v6_r;
  logic signed [ACC_W-1:0] pax6_r, pbx6_r, pay6_r, pby6_r;
  // Stage 7: full sums.
  logic                    v7_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  // Output register.
  logic                    out_valid_r;
  logic [COORD_W-1:0]      out_x_r, out_y_r;

  logic [BSUM_W-1:0] bsum [NUM_ROLES];
  logic [FRAC_W-1:0] s_head;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [RES_W-1:0] r);
    logic fits;
    fits = (r[RES_W-1:COORD_W-1] == '0) || (r[RES_W-1:COORD_W-1] == '1);
    if (fits) begin
      return r[COORD_W-1:0];
    end
    return r[RES_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  // Advance the whole pipe whenever the output slot is free or being taken.
  assign en         = !out_valid_r || out_tready;
  assign pop        = en && !q_stat.empty;
  assign s_head     = ONE_Q16 - head.frac;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};

  always_comb begin
    raw3_nxt[ROLE_START] = RAW_W'(sqs2_r) * RAW_W'(s2_r);
    raw3_nxt[ROLE_CTRL1] = RAW_W'(sqs2_r) * RAW_W'(f2_r);
    raw3_nxt[ROLE_CTRL2] = RAW_W'(sqf2_r) * RAW_W'(s2_r);
    raw3_nxt[ROLE_END]   = RAW_W'(sqf2_r) * RAW_W'(f2_r);

    // Middle weights carry the factor of three.
    bsum[ROLE_START] = BSUM_W'(raw3_r[ROLE_START]) + WGT_ROUND;
    bsum[ROLE_CTRL1] = BSUM_W'(raw3_r[ROLE_CTRL1]) + {1'b0, raw3_r[ROLE_CTRL1], 1'b0}
                       + WGT_ROUND;
    bsum[ROLE_CTRL2] = BSUM_W'(raw3_r[ROLE_CTRL2]) + {1'b0, raw3_r[ROLE_CTRL2], 1'b0}
                       + WGT_ROUND;
    bsum[ROLE_END]   = BSUM_W'(raw3_r[ROLE_END]) + WGT_ROUND;

    for (int k = 0; k < NUM_ROLES; k++) begin
      w4_nxt[k]  = bsum[k][WGT_SH +: WGT_W];
      px5_nxt[k] = $signed(pt4_r[k][COORD_W-1:0]) * $signed({1'b0, w4_r[k]});
      py5_nxt[k] = $signed(pt4_r[k][PT_W-1:COORD_W]) * $signed({1'b0, w4_r[k]});
    end
  end

  // Control point banks: write a load, read the evaluated segment.
  always_ff @(posedge clk) begin
    if (pop && !head.eval) begin
      bank_mem[head.role][head.addr] <= {head.y, head.x};
    end
    if (en) begin
      for (int k = 0; k < NUM_ROLES; k++) begin
        rd_r[k] <= bank_mem[k][head.addr];
      end
    end
  end

  // Valid chain; loads drop out after the bank write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop && head.eval;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= head.frac;
      s1_r   <= s_head;
      f2_r   <= f1_r;
      s2_r   <= s1_r;
      sqs2_r <= SQ_W'(s1_r) * SQ_W'(s1_r);
      sqf2_r <= SQ_W'(f1_r) * SQ_W'(f1_r);
      for (int k = 0; k < NUM_ROLES; k++) begin
        pt2_r[k]  <= rd_r[k];
        pt3_r[k]  <= pt2_r[k];
        pt4_r[k]  <= pt3_r[k];
        raw3_r[k] <= raw3_nxt[k];
        w4_r[k]   <= w4_nxt[k];
        px5_r[k]  <= px5_nxt[k];
        py5_r[k]  <= py5_nxt[k];
      end
      pax6_r  <= px5_r[ROLE_START] + px5_r[ROLE_CTRL1] + ACC_ROUND;
      pbx6_r  <= px5_r[ROLE_CTRL2] + px5_r[ROLE_END];
      pay6_r  <= py5_r[ROLE_START] + py5_r[ROLE_CTRL1] + ACC_ROUND;
      pby6_r  <= py5_r[ROLE_CTRL2] + py5_r[ROLE_END];
      acc_x_r <= pax6_r + pbx6_r;
      acc_y_r <= pay6_r + pby6_r;
      out_x_r <= sat_coord(acc_x_r[ACC_W-1:ACC_SH]);
      out_y_r <= sat_coord(acc_y_r[ACC_W-1:ACC_SH]);
    end
  end

  `PCBE_ASSERT_NEXT(a_out_from_pipe, en, out_valid_r == $past(v7_r), "output valid lost or invented")
  `PCBE_ASSERT_NEXT(a_hold_on_stall, !en, $stable(v7_r) && $stable(out_tdata), "pipe moved on stall")
  `PCBE_ASSERT_NOW(a_pop_only_on_en, pop, en, "queue drained while pipe stalled")

endmodule

// ===== sv/piecewise_cubic_bezier_eval.sv =====
// Top level of the piecewise cubic Bezier evaluator.
// Depends on pcbe_pkg, pcbe_front, pcbe_queue and pcbe_back.
//
// Evaluates a table of up to 64 cubic Bezier segments (four Q15.16 x,y points each) at a
// global parameter t in Q1.16. A load item (tuser func = 0) writes one point into one
// segment and returns nothing; an evaluate item (func = 1) maps t onto segment floor(t*n)
// at local fraction t*n - index (t = 1.0 lands on the last segment at fraction 1.0) and
// returns the Bernstein-weighted point, rounded and saturated to 32 bits. The block takes
// one item per cycle while the back pipeline is not stalled by out_tready. An accepted
// item is classified in a front register, waits in a four-entry queue, then runs an
// eight-stage back pipeline: bank read, squares, cubes, weights, multiply, two adder
// levels and the output register. Throughput is set by that back pipeline, which advances
// whenever its output register is empty or being taken; the point table is split into
// four banks by point role so all four points of a segment read together. Reading a point
// that was never loaded gives an undefined value. Write segment_count only while no
// evaluate is in flight; 0 acts as 1, values above 64 act as 64.
module piecewise_cubic_bezier_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // segment_index[5:0], point_role[7:6], load_x[39:8], load_y[71:40],
  // curve_param[88:72], zero fill [95:89]
  input  logic [pcbe_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[0]
  input  logic [pcbe_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result items.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // point_x[31:0], point_y[63:32]
  output logic [pcbe_pkg::OUT_TDATA_W-1:0] out_tdata,
  // segment_count write.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcbe_pkg::CNT_W-1:0]       cfg_data
);
  import pcbe_pkg::*;

  pcbe_qstat_t q_stat;
  pcbe_item_t  push_item;
  pcbe_item_t  head;
  logic        push;
  logic        pop;

  // Accept and classify.
  pcbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple the two halves so each can stall on its own.
  pcbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Store loads, evaluate curve points.
  pcbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/piecewise_cubic_bezier_eval_test.sv =====
// Self-checking testbench for the piecewise cubic Bezier evaluator.
// Depends on pcbe_pkg and piecewise_cubic_bezier_eval; predicts each evaluated point itself.
module piecewise_cubic_bezier_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcbe_pkg::*;

  // Run shape.
  localparam int PHASE_ITEMS  = 185;   // random items per segment_count setting
  localparam int DRAIN_CYCLES = 32;    // front register, queue and back pipeline, with margin
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off to fill the block
  localparam int HOLD_AT      = 40;    // result count at which the hold-off starts
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int RUN_LEN      = 48;    // items per stretch of idling or back-to-back traffic

  // Scoreboard: keeps its own copy of the point table and segment count, computes the
  // Bernstein-weighted point for every accepted evaluate and checks results in order.
  class bezier_scoreboard;
    logic signed [COORD_W-1:0] tab_x [NUM_ROLES*MAX_SEGMENTS];
    logic signed [COORD_W-1:0] tab_y [NUM_ROLES*MAX_SEGMENTS];
    logic [CNT_W-1:0]          seg_count;
    logic [OUT_TDATA_W-1:0]    expected_points [$];
    int unsigned               mismatches;
    int unsigned               checked;

    function new();
      seg_count  = CNT_W'(1);
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      seg_count = value;
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction

    // Round the Q30 sum to nearest (half up) and clamp to the coordinate range.
    function logic [COORD_W-1:0] round_sat(longint signed acc);
      longint signed r;
      r = (acc + 64'sd536870912) >>> ACC_SH;
      if (r > 64'sd2147483647) return COORD_MAX;
      if (r < -64'sd2147483648) return COORD_MIN;
      return r[COORD_W-1:0];
    endfunction

    function logic [OUT_TDATA_W-1:0] bezier_point(logic [FRAC_W-1:0] t_in);
      int unsigned     n, t, idx, f, k;
      longint unsigned s, fu;
      longint unsigned bern [NUM_ROLES];
      longint signed   wgt, acc_x, acc_y;
      n = 32'(seg_count);
      if (n < 1) n = 1;
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      t = 32'(t_in);
      if (t > 65536) t = 65536;
      // t = 1.0 lands on the last segment at local fraction 1.0
      if (t == 65536) begin
        idx = n - 1;
        f   = 65536;
      end else begin
        idx = (t * n) >> FBITS;
        f   = (t * n) & 32'hFFFF;
      end
      s  = 64'(65536 - f);
      fu = 64'(f);
      bern[0] = s * s * s;
      bern[1] = 3 * s * s * fu;
      bern[2] = 3 * s * fu * fu;
      bern[3] = fu * fu * fu;
      acc_x = 0;
      acc_y = 0;
      for (k = 0; k < NUM_ROLES; k++) begin
        wgt   = longint'((bern[k] + 64'd131072) >> WGT_SH);
        acc_x += longint'(tab_x[idx*NUM_ROLES + k]) * wgt;
        acc_y += longint'(tab_y[idx*NUM_ROLES + k]) * wgt;
      end
      return {round_sat(acc_y), round_sat(acc_x)};
    endfunction

    function void note_item(logic fn, logic [IN_TDATA_W-1:0] data);
      int unsigned slot;
      if (fn == FUNC_LOAD) begin
        slot = data[SEG_LSB +: SEG_W] * NUM_ROLES + data[ROLE_LSB +: 2];
        tab_x[slot] = data[X_LSB +: COORD_W];
        tab_y[slot] = data[Y_LSB +: COORD_W];
      end else begin
        expected_points.insert(expected_points.size(), bezier_point(data[T_LSB +: FRAC_W]));
      end
    endfunction

    function void check_point(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x=%h y=%h", got[31:0], got[63:32]);
        return;
      end
      want = expected_points.pop_front();
      checked++;
      if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point %0d: expected x=%h y=%h, got x=%h y=%h", checked,
                   want[31:0], want[63:32], got[31:0], got[63:32]);
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // segment_index, point_role, load_x, load_y, curve_param, zero fill (lowest bit first)
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  // func
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // point_x, point_y (lowest bit first)
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data  = '0;

  bezier_scoreboard sb = new();

  // Which points of each segment have been loaded; evaluates only hit complete segments.
  bit [NUM_ROLES-1:0] seg_roles [MAX_SEGMENTS];
  int n_loads, n_evals, n_cfg;
  int send_run_left, stall_cycles;
  bit send_steady;

  piecewise_cubic_bezier_eval uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: any accepted item on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d points outstanding", stall_cycles,
               sb.pending());
      $display("piecewise_cubic_bezier_eval: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [SEG_W-1:0] seg, role_t role,
                                                      logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y,
                                                      logic [FRAC_W-1:0] t);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[SEG_LSB +: SEG_W]    = seg;
    d[ROLE_LSB +: 2]       = role;
    d[X_LSB +: COORD_W]    = x;
    d[Y_LSB +: COORD_W]    = y;
    d[T_LSB +: FRAC_W]     = t;
    return d;
  endfunction

  // Mix the coordinate extremes into otherwise random point data.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int effective_count(int value);
    if (value < 1) return 1;
    if (value > MAX_SEGMENTS) return MAX_SEGMENTS;
    return value;
  endfunction

  // Offer one item after a random gap (or none in a back-to-back stretch); hold it until
  // taken. Valid stays high into the next call unless that call idles first.
  task automatic push_item(input logic fn, input logic [IN_TDATA_W-1:0] data);
    int gap;
    if (send_run_left == 0) begin
      send_steady   = ($urandom_range(0, 3) == 0);
      send_run_left = RUN_LEN;
    end
    send_run_left--;
    gap = send_steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= fn;
    do @(posedge clk); while (!in_tready);
    sb.note_item(fn, data);
    if (fn == FUNC_EVAL) n_evals++;
    else n_loads++;
  endtask

  // A load carries a random curve_param that the block must ignore.
  task automatic load_point(input int seg, input role_t role, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
    push_item(FUNC_LOAD, pack_item(SEG_W'(seg), role, x, y,
                                   FRAC_W'($urandom_range(0, 17'h1FFFF))));
    seg_roles[seg][role] = 1'b1;
  endtask

  // An evaluate carries random segment, role and point fields that must be ignored.
  task automatic eval_at(input int t);
    push_item(FUNC_EVAL, pack_item(SEG_W'($urandom_range(0, MAX_SEGMENTS - 1)),
                                   role_t'($urandom_range(0, 3)), $urandom, $urandom,
                                   FRAC_W'(t)));
  endtask

  // Drop valid, wait for every expected point, then let loads still in the pipe retire.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(value[CNT_W-1:0]);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random step: mostly a complete four-point segment load or an evaluate aimed at a
  // complete segment, sometimes a lone point load that leaves a segment partial.
  task automatic random_step(input int eff);
    int pick, seg, idx, lo, hi, r0, k;
    int full_list [$];
    bit last_full;
    for (k = 0; k < eff; k++)
      if (seg_roles[k] == '1) full_list.insert(full_list.size(), k);
    last_full = (seg_roles[eff-1] == '1);
    pick = $urandom_range(0, 99);
    if (full_list.size() == 0 || pick < 20) begin
      // mostly segments in use, occasionally any row of the table
      seg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_SEGMENTS - 1)
                                        : $urandom_range(0, eff - 1);
      r0 = $urandom_range(0, NUM_ROLES - 1);
      for (k = 0; k < NUM_ROLES; k++)
        load_point(seg, role_t'((r0 + k) % NUM_ROLES), rand_coord(), rand_coord());
    end else if (pick < 28) begin
      load_point($urandom_range(0, MAX_SEGMENTS - 1), role_t'($urandom_range(0, 3)),
                 rand_coord(), rand_coord());
    end else if (pick < 33 && last_full) begin
      // parameter above one clamps onto the end of the last segment
      eval_at(65537 + $urandom_range(0, 65534));
    end else if (pick < 36 && last_full) begin
      eval_at(65536);
    end else begin
      idx = full_list[$urandom_range(0, full_list.size() - 1)];
      lo  = (idx * 65536 + eff - 1) / eff;
      hi  = ((idx + 1) * 65536 + eff - 1) / eff - 1;
      case ($urandom_range(0, 9))
        0:       eval_at(lo);
        1:       eval_at(hi);
        default: eval_at($urandom_range(lo, hi));
      endcase
    end
  endtask

  // Result side: random tready gaps, back-to-back stretches, and one long hold-off while
  // the sender keeps offering so the queue fills and in_tready drops.
  initial begin : result_sink
    int gap, seen, run_left;
    bit steady, held;
    seen     = 0;
    run_left = 0;
    steady   = 1'b0;
    held     = 1'b0;
    @(posedge rst_n);
    forever begin
      if (run_left == 0) begin
        steady   = ($urandom_range(0, 3) == 0);
        run_left = RUN_LEN;
      end
      run_left--;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (!held && seen == HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_point(out_tdata);
      seen++;
    end
  end

  initial begin : stimulus
    int cfg_plan [8];
    int p, eff, start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: segment_count is at its reset value of one. Fill segment 0 with the
    // positive x and negative y extremes so the weight rounding pushes into saturation.
    load_point(0, ROLE_START, COORD_MAX, COORD_MIN);
    load_point(0, ROLE_CTRL1, COORD_MAX, COORD_MIN);
    load_point(0, ROLE_CTRL2, COORD_MAX, COORD_MIN);
    load_point(0, ROLE_END,   COORD_MAX, COORD_MIN);
    eval_at(0);
    eval_at(1);
    eval_at(32768);
    eval_at(65535);
    eval_at(65536);          // exactly one: last segment at fraction one
    eval_at(65537);          // just above one: clamped
    eval_at(17'h1FFFF);      // largest encodable parameter
    // Mixed points, including the opposite extremes and sign boundaries.
    load_point(0, ROLE_START, '0, '1);
    load_point(0, ROLE_CTRL1, COORD_MIN, COORD_MAX);
    load_point(0, ROLE_CTRL2, COORD_MAX, 32'h0001_0000);
    load_point(0, ROLE_END,   32'hFFFF_0000, 32'h0000_3039);
    eval_at(21845);
    eval_at(49152);
    eval_at(65536);

    // Zero acts as one; 127, 65 and a random value from 66 to 126 act as 64; the rest are in range.
    cfg_plan = '{0, 64, 127, 2, 65, 1, 0, 0};
    cfg_plan[6] = $urandom_range(3, 63);
    cfg_plan[7] = $urandom_range(66, 126);
    for (p = 0; p < 8; p++) begin
      drain();
      write_count(cfg_plan[p]);
      eff   = effective_count(cfg_plan[p]);
      start = n_loads + n_evals;
      while (n_loads + n_evals - start < PHASE_ITEMS) random_step(eff);
    end

    drain();
    $display("covered %0d loads and %0d evaluates over %0d segment_count settings",
             n_loads, n_evals, n_cfg + 1);
    $display("checked %0d points, %0d mismatches, %0d still expected", sb.checked,
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("piecewise_cubic_bezier_eval: match");
    end else begin
      $display("piecewise_cubic_bezier_eval: mismatch");
    end
    $finish;
  end

endmodule
